FILE: design/fic_pkg.sv
// Shared types, codes and constants of the firmware image checker.
`default_nettype none

package fic_pkg;

    localparam int HEADER_BYTES = 64;
    localparam int LENGTH_BITS  = 32;
    localparam int SEG_COUNT    = 4;
    localparam int POS_W        = $clog2(HEADER_BYTES);
    localparam int MAGIC_W      = 32;
    localparam int SUM_W        = 16;

    localparam logic [MAGIC_W-1:0] MAGIC_RESET = 32'h5500_5678;

    localparam logic [POS_W-1:0] LAST_HDR_POS = POS_W'(HEADER_BYTES - 1);

    // Per-segment keys: loader, bootloader, kernel, rootfs
    localparam logic [7:0] SEG_KEYS [SEG_COUNT] = '{8'h73, 8'h75, 8'h6B, 8'h72};

    // Phase codes; the segment phases 1..4 double as section tags
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SEG1   = 3'd1;
    localparam logic [2:0] PH_SEG4   = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    // Section tags
    localparam logic [2:0] SEC_HEADER   = 3'd0;
    localparam logic [2:0] SEC_TRAILING = 3'd5;

    // Verdict codes
    localparam logic [2:0] VERD_OK       = 3'd0;
    localparam logic [2:0] VERD_MAGIC    = 3'd1;
    localparam logic [2:0] VERD_SEG_BASE = 3'd2;
    localparam logic [2:0] VERD_TRUNC    = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [2:0] section;
        logic       verdict_valid;
        logic [2:0] verdict;
    } result_t;

endpackage

`default_nettype wire

FILE: design/fic_core.sv
// Image state and per-beat processing of the firmware image checker.
`default_nettype none

module fic_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         step,
    input  wire fic_pkg::item_t               item,
    input  wire logic [fic_pkg::MAGIC_W-1:0]  expected_magic,
    output fic_pkg::result_t                  res
);
    import fic_pkg::*;

    logic [2:0]             phase_reg,  phase_next;
    logic [POS_W-1:0]       pos_reg,    pos_next;
    logic [MAGIC_W-1:0]     magic_reg,  magic_next;
    logic [SUM_W-1:0]       sums_reg    [SEG_COUNT];
    logic [SUM_W-1:0]       sums_next   [SEG_COUNT];
    logic [LENGTH_BITS-1:0] len_reg     [SEG_COUNT];
    logic [LENGTH_BITS-1:0] len_next    [SEG_COUNT];
    logic [LENGTH_BITS-1:0] rem_reg,    rem_next;
    logic [7:0]             acc_reg,    acc_next;
    logic [7:0]             cnt_reg,    cnt_next;
    logic [2:0]             err_reg,    err_next;

    // Search for the next non-empty segment from a start index
    logic [2:0] ent_start;
    logic [2:0] ent_phase;
    logic [1:0] ent_sel;
    logic [2:0] ent_err;

    always_comb begin
        logic found;
        found     = 1'b0;
        ent_phase = PH_DONE;
        ent_sel   = 2'd0;
        ent_err   = VERD_OK;
        for (int i = 0; i < SEG_COUNT; i++) begin
            if (3'(i) >= ent_start && !found) begin
                if (len_reg[i] != '0) begin
                    found     = 1'b1;
                    ent_phase = 3'(i) + 3'd1;
                    ent_sel   = 2'(i);
                end else if (sums_reg[i] != '0 && ent_err == VERD_OK) begin
                    ent_err = VERD_SEG_BASE + 3'(i);
                end
            end
        end
    end

    always_comb begin
        logic [7:0]       b;
        logic [1:0]       seg;
        logic             enter;
        logic [SUM_W-1:0] seg_sum;
        logic [31:0]      len_wide;
        logic [SUM_W-1:0] sum_wide;

        b          = item.data_byte;
        seg        = 2'(phase_reg - PH_SEG1);
        enter      = 1'b0;
        ent_start  = 3'd0;
        seg_sum    = '0;
        len_wide   = '0;
        sum_wide   = '0;

        phase_next = phase_reg;
        pos_next   = pos_reg;
        magic_next = magic_reg;
        sums_next  = sums_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;

        res.byte_out      = b;
        res.verdict_valid = item.last_byte;
        res.verdict       = VERD_OK;
        res.section       = SEC_TRAILING;

        if (phase_reg == PH_HEADER) begin
            res.section = SEC_HEADER;
            if (pos_reg[5:2] == 4'd0) begin
                magic_next[8*pos_reg[1:0] +: 8] = b;
            end else if (pos_reg[5:3] == 3'd1) begin
                sum_wide = sums_reg[pos_reg[2:1]];
                sum_wide[8*pos_reg[0] +: 8] = b;
                sums_next[pos_reg[2:1]] = sum_wide;
            end else if (pos_reg[5:4] == 2'd1) begin
                len_wide = 32'(len_reg[pos_reg[3:2]]);
                len_wide[8*pos_reg[1:0] +: 8] = b;
                len_next[pos_reg[3:2]] = len_wide[LENGTH_BITS-1:0];
            end
            if (pos_reg == LAST_HDR_POS) begin
                if (magic_reg != expected_magic && err_next == VERD_OK) begin
                    err_next = VERD_MAGIC;
                end
                enter     = 1'b1;
                ent_start = 3'd0;
            end else begin
                pos_next = pos_reg + POS_W'(1);
            end
        end else if (phase_reg >= PH_SEG1 && phase_reg <= PH_SEG4) begin
            res.section = phase_reg;
            if (b == SEG_KEYS[seg]) begin
                cnt_next = cnt_reg + 8'd1;
            end else begin
                acc_next = acc_reg ^ b;
            end
            rem_next = rem_reg - LENGTH_BITS'(1);
            if (rem_reg == LENGTH_BITS'(1)) begin
                seg_sum = {cnt_next, acc_next};
                if (seg_sum != sums_reg[seg] && err_next == VERD_OK) begin
                    err_next = VERD_SEG_BASE + 3'(seg);
                end
                enter     = 1'b1;
                ent_start = phase_reg;
            end
        end

        if (enter) begin
            phase_next = ent_phase;
            if (ent_phase == PH_DONE) begin
                rem_next = '0;
            end else begin
                rem_next = len_reg[ent_sel];
                acc_next = SEG_KEYS[ent_sel];
                cnt_next = SEG_KEYS[ent_sel];
            end
            if (ent_err != VERD_OK && err_next == VERD_OK) begin
                err_next = ent_err;
            end
        end

        if (item.last_byte) begin
            if (err_next != VERD_OK) begin
                res.verdict = err_next;
            end else if (phase_next != PH_DONE) begin
                res.verdict = VERD_TRUNC;
            end
            // Drop the image walk state (header fields are rewritten later); the next beat opens a new header
            phase_next = PH_HEADER;
            pos_next   = '0;
            rem_next   = '0;
            acc_next   = '0;
            cnt_next   = '0;
            err_next   = VERD_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            rem_reg   <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            err_reg   <= VERD_OK;
        end else if (step) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            rem_reg   <= rem_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
        end
    end

    // Header fields are fully rewritten before any read, so they need no reset
    always_ff @(posedge aclk) begin
        if (step) begin
            magic_reg <= magic_next;
            sums_reg  <= sums_next;
            len_reg   <= len_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/firmware_image_checker.sv
// Top level of the firmware image checker: handshake stages, magic register and core.
`default_nettype none

// Firmware image checker.
// The s_ channel takes an image one byte per beat; s_last_byte marks the final
// byte, and the next beat starts a new image. The first 64 bytes are the
// little-endian header (magic, four 16-bit sums, four segment lengths); the
// four segments follow and are summed with their own keys.
// Every beat comes out on the m_ channel with the byte unchanged and its section
// tag. On the last byte m_verdict_valid is high and m_verdict carries the first
// failure: bad magic, a segment sum in order, or truncation.
// An accepted s_ beat goes through the input register, then the processing pass
// into the result register, which raises m_valid. Throughput: one beat per cycle
// while m_ready does not stall the result register; the per-beat segment work
// is a compare, an XOR or an increment, and a length decrement in a single pass.
// Stalls: while m_ready is low the result register holds; the input register
// still takes one more beat, after which s_ready drops until the result moves.
// cfg_wr_en writes the expected magic word at once; write it only while idle.
// Reset (aresetn low, synchronous) empties both stages, returns the image state
// to the start of a header and loads the default magic 0x55005678.
module firmware_image_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [fic_pkg::MAGIC_W-1:0] cfg_wr_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [7:0]                  s_data_byte,
    input  wire logic                        s_last_byte,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [7:0]                       m_byte_out,
    output logic [2:0]                       m_section,
    output logic                             m_verdict_valid,
    output logic [2:0]                       m_verdict
);
    import fic_pkg::*;

    logic [MAGIC_W-1:0] magic_cfg_reg;
    logic               in_valid_reg;
    item_t              in_item_reg;
    logic               out_valid_reg;
    result_t            out_res_reg;
    result_t            core_res;
    logic               advance;

    // Advance the input beat when the result register is empty or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_cfg_reg <= MAGIC_RESET;
        end else if (cfg_wr_en) begin
            magic_cfg_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.data_byte <= s_data_byte;
            in_item_reg.last_byte <= s_last_byte;
        end
    end

    fic_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (advance),
        .item           (in_item_reg),
        .expected_magic (magic_cfg_reg),
        .res            (core_res)
    );

    // Result register: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_byte_out      = out_res_reg.byte_out;
    assign m_section       = out_res_reg.section;
    assign m_verdict_valid = out_res_reg.verdict_valid;
    assign m_verdict       = out_res_reg.verdict;

endmodule

`default_nettype wire

FILE: design/fic_checker.sv
// Port-level assertions for the firmware image checker, bound to the top level.
`default_nettype none

module fic_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic [7:0]                  s_data_byte,
    input wire logic                        s_last_byte,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [7:0]                  m_byte_out,
    input wire logic [2:0]                  m_section,
    input wire logic                        m_verdict_valid,
    input wire logic [2:0]                  m_verdict
);
    import fic_pkg::*;

    // A waiting input beat holds until it is taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data_byte) && $stable(s_last_byte))
        else $error("input beat changed while waiting");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_byte_out) && $stable(m_section)
            && $stable(m_verdict_valid) && $stable(m_verdict))
        else $error("result beat changed while stalled");

    a_verdict_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_verdict_valid |-> m_verdict == VERD_OK)
        else $error("verdict set on a beat that is not the last");

    a_trailing_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_verdict_valid && m_section == SEC_TRAILING |-> m_verdict != VERD_TRUNC)
        else $error("truncation reported after the last segment");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind firmware_image_checker fic_checker u_fic_checker (.*);

`default_nettype wire

FILE: tb/firmware_image_checker_tb.sv
// Self-checking testbench for the firmware image checker: streamed images against a predictor.
`timescale 1ns / 1ps

module firmware_image_checker_tb;
    import fic_pkg::*;

    typedef int unsigned seg_len_t [SEG_COUNT];

    // Chance, in percent per cycle, that either side idles
    localparam int IDLE_PCT = 7;
    localparam logic [31:0] LEN_MASK = 32'hFFFF_FFFF >> (32 - LENGTH_BITS);

    // Block ports; every input starts at a known level
    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [MAGIC_W-1:0] cfg_wr_data = '0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [7:0]         s_data_byte = '0;
    logic               s_last_byte = 1'b0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic [7:0]         m_byte_out;
    logic [2:0]         m_section;
    logic               m_verdict_valid;
    logic [2:0]         m_verdict;

    // Predictor state: a private copy of the magic register and the image walk
    logic [MAGIC_W-1:0] magic_reg;
    logic [2:0]         img_phase;
    logic [POS_W-1:0]   hdr_pos;
    logic [MAGIC_W-1:0] magic_got;
    logic [SUM_W-1:0]   sum_want [SEG_COUNT];
    logic [31:0]        seg_len [SEG_COUNT];
    logic [31:0]        bytes_left;
    logic [7:0]         xor_acc;
    logic [7:0]         key_cnt;
    logic [2:0]         first_fail;

    // Beats predicted but not yet seen on the m_ side, oldest first
    result_t            beats_due [$];
    // Image under construction, streamed one byte per beat
    logic [7:0]         image_bytes [$];

    bit                 quiet_stretch = 1'b0;
    int                 fail_count    = 0;
    int                 beats_sent    = 0;
    int                 images_sent   = 0;
    int                 magic_writes  = 0;
    int                 verdict_tally [8];

    firmware_image_checker dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_out     (m_byte_out),
        .m_section      (m_section),
        .m_verdict_valid(m_verdict_valid),
        .m_verdict      (m_verdict)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Drop everything learnt about the current image; the magic register stays
    function automatic void clear_image_state();
        img_phase  = PH_HEADER;
        hdr_pos    = '0;
        magic_got  = '0;
        bytes_left = '0;
        xor_acc    = '0;
        key_cnt    = '0;
        first_fail = VERD_OK;
        for (int k = 0; k < SEG_COUNT; k++) begin
            sum_want[k] = '0;
            seg_len[k]  = '0;
        end
    endfunction

    // Only the first failure of an image is kept
    function automatic void record_fail(input logic [2:0] code);
        if (first_fail == VERD_OK) begin
            first_fail = code;
        end
    endfunction

    // Step into segment 'first'; empty segments are judged at once and skipped
    function automatic void open_segment(input int first);
        int seg;
        seg = first;
        while (seg < SEG_COUNT && seg_len[seg] == '0) begin
            if (sum_want[seg] != '0) begin
                record_fail(VERD_SEG_BASE + 3'(seg));
            end
            seg++;
        end
        if (seg < SEG_COUNT) begin
            img_phase  = PH_SEG1 + 3'(seg);
            bytes_left = seg_len[seg];
            xor_acc    = SEG_KEYS[seg];
            key_cnt    = SEG_KEYS[seg];
        end else begin
            img_phase  = PH_DONE;
            bytes_left = '0;
        end
    endfunction

    // Work out the result beat caused by one image byte and advance the walk
    function automatic result_t predict_beat(input logic [7:0] b, input logic is_last);
        result_t r;
        int      pos;
        int      seg;
        r.byte_out      = b;
        r.verdict_valid = is_last;
        r.verdict       = VERD_OK;
        if (img_phase == PH_HEADER) begin
            r.section = SEC_HEADER;
            pos = int'(hdr_pos);
            // Little-endian fields; the total length and the text are ignored
            if (pos < 4) begin
                magic_got[8*pos +: 8] = b;
            end else if (pos >= 8 && pos < 16) begin
                sum_want[(pos-8)/2][8*((pos-8)%2) +: 8] = b;
            end else if (pos >= 16 && pos < 32) begin
                seg_len[(pos-16)/4][8*((pos-16)%4) +: 8] = b;
                seg_len[(pos-16)/4] &= LEN_MASK;
            end
            if (pos == HEADER_BYTES - 1) begin
                if (magic_got != magic_reg) begin
                    record_fail(VERD_MAGIC);
                end
                open_segment(0);
            end else begin
                hdr_pos = hdr_pos + 1'b1;
            end
        end else if (img_phase != PH_DONE) begin
            r.section = img_phase;
            seg = int'(img_phase) - 1;
            // Key bytes are counted, all others folded into the XOR
            if (b == SEG_KEYS[seg]) begin
                key_cnt = key_cnt + 1'b1;
            end else begin
                xor_acc = xor_acc ^ b;
            end
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == '0) begin
                if ({key_cnt, xor_acc} != sum_want[seg]) begin
                    record_fail(VERD_SEG_BASE + 3'(seg));
                end
                open_segment(seg + 1);
            end
        end else begin
            r.section = SEC_TRAILING;
        end
        if (is_last) begin
            // An earlier failure outranks an early end
            if (first_fail != VERD_OK) begin
                r.verdict = first_fail;
            end else if (img_phase != PH_DONE) begin
                r.verdict = VERD_TRUNC;
            end
            clear_image_state();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the field-by-field check
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        m_ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (beats_due.size() == 0) begin
                $error("result beat with nothing expected: byte %0d section %0d",
                       m_byte_out, m_section);
                fail_count++;
            end else begin
                want = beats_due.pop_front();
                compare_field("byte_out", want.byte_out, m_byte_out);
                compare_field("section", want.section, m_section);
                compare_field("verdict_valid", want.verdict_valid, m_verdict_valid);
                compare_field("verdict", want.verdict, m_verdict);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one byte; entered and left at a rising edge. Valid is only lowered
    // when an idle gap is drawn, so back-to-back beats keep it high.
    task automatic send_beat(input logic [7:0] b, input logic is_last);
        int      gap;
        result_t want;
        gap = 0;
        while (!quiet_stretch && $urandom_range(99) < IDLE_PCT) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= is_last;
        do @(posedge aclk); while (!s_ready);
        want = predict_beat(b, is_last);
        beats_due.push_back(want);
        beats_sent++;
        if (is_last) begin
            verdict_tally[want.verdict]++;
        end
    endtask

    // Hold the sender off until every predicted beat has come out, then let
    // the pipeline run dry
    task automatic settle();
        int waited;
        s_valid <= 1'b0;
        waited = 0;
        while (beats_due.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
    endtask

    // Only call while idle: straight after reset or after settle()
    task automatic write_magic(input logic [MAGIC_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        magic_reg = value;
        magic_writes++;
        @(posedge aclk);
    endtask

    // Assemble a complete image: header, four segments with random content
    // (key_pct percent key bytes), then trailing bytes. Sums are worked out
    // here; a set bit in bad_sum flips one bit of that segment's stored sum.
    function automatic void build_image(input logic [MAGIC_W-1:0] magic, input seg_len_t lens,
                                        input logic [SEG_COUNT-1:0] bad_sum,
                                        input int trailing, input int key_pct);
        logic [7:0]       body [$];
        logic [SUM_W-1:0] sums [SEG_COUNT];
        logic [7:0]       acc;
        logic [7:0]       cnt;
        logic [7:0]       b;
        logic [7:0]       key;
        image_bytes.delete();
        for (int k = 0; k < SEG_COUNT; k++) begin
            key = SEG_KEYS[k];
            acc = key;
            cnt = key;
            for (int unsigned i = 0; i < lens[k]; i++) begin
                b = ($urandom_range(99) < key_pct) ? key : 8'($urandom_range(255));
                if (b == key) begin
                    cnt = cnt + 1'b1;
                end else begin
                    acc = acc ^ b;
                end
                body.push_back(b);
            end
            sums[k] = (lens[k] == 0) ? '0 : {cnt, acc};
            if (bad_sum[k]) begin
                sums[k] ^= SUM_W'(1) << $urandom_range(SUM_W - 1);
            end
        end
        for (int i = 0; i < HEADER_BYTES; i++) begin
            if (i < 4) begin
                b = magic[8*i +: 8];
            end else if (i >= 8 && i < 16) begin
                b = sums[(i-8)/2][8*((i-8)%2) +: 8];
            end else if (i >= 16 && i < 32) begin
                b = 8'(lens[(i-16)/4] >> (8*((i-16)%4)));
            end else begin
                b = 8'($urandom_range(255));
            end
            image_bytes.push_back(b);
        end
        foreach (body[i]) begin
            image_bytes.push_back(body[i]);
        end
        repeat (trailing) image_bytes.push_back(8'($urandom_range(255)));
    endfunction

    // Cut the image short so that it ends after 'keep' bytes
    function automatic void cut_image(input int keep);
        while (image_bytes.size() > keep) begin
            void'(image_bytes.pop_back());
        end
    endfunction

    task automatic stream_image();
        for (int i = 0; i < image_bytes.size(); i++) begin
            send_beat(image_bytes[i], i == image_bytes.size() - 1);
        end
        images_sent++;
    endtask

    function automatic seg_len_t pick_lengths();
        seg_len_t lens;
        for (int k = 0; k < SEG_COUNT; k++) begin
            // Mostly short segments, the odd longer one, and empty ones often
            case ($urandom_range(9))
                0, 1:    lens[k] = 0;
                2:       lens[k] = $urandom_range(20, 48);
                default: lens[k] = $urandom_range(1, 8);
            endcase
        end
        return lens;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Good image under the reset magic with trailing bytes, and a key run long
    // enough that the count wraps past 0xff; neither side idles throughout
    task automatic test_key_count_wrap();
        quiet_stretch = 1'b1;
        build_image(MAGIC_RESET, '{0, 145, 0, 1}, 4'b0000, 3, 99);
        stream_image();
        quiet_stretch = 1'b0;
    endtask

    // Empty segments with a stored non-zero sum fail, both when skipped at the
    // header end and when skipped after a finished segment
    task automatic test_empty_segments();
        build_image(MAGIC_RESET, '{0, 2, 0, 0}, 4'b0001, 0, 25);
        stream_image();
        build_image(MAGIC_RESET, '{1, 0, 0, 0}, 4'b1000, 1, 25);
        stream_image();
    endtask

    // Bad magic outranks sums; a sum failure outranks a later truncation
    task automatic test_error_priority();
        build_image(MAGIC_RESET ^ 32'h0000_0100, '{1, 1, 0, 0}, 4'b0110, 0, 25);
        stream_image();
        build_image(MAGIC_RESET, '{1, 2, 2, 1}, 4'b0110, 0, 25);
        cut_image(HEADER_BYTES + 1 + 2 + 1);
        stream_image();
    endtask

    // Early ends: on the first byte, right after the magic, and with lengths
    // far longer than the image
    task automatic test_truncation();
        build_image(MAGIC_RESET, '{1, 1, 1, 1}, 4'b0000, 0, 25);
        cut_image(1);
        stream_image();
        build_image(MAGIC_RESET, '{1, 1, 1, 1}, 4'b0000, 0, 25);
        cut_image(4);
        stream_image();
        // Length 0 all ones, top bytes of lengths 1 and 3 set: the segment never completes
        build_image(MAGIC_RESET, '{3, 0, 0, 0}, 4'b0000, 0, 25);
        for (int i = 16; i < 20; i++) begin
            image_bytes[i] = 8'hFF;
        end
        image_bytes[23] = 8'h80;
        image_bytes[31] = 8'h7F;
        stream_image();
    endtask

    // Rewrite the magic register, check an all-empty image passes under it and
    // the reset word fails, then leave a random word for the random images
    task automatic test_magic_register();
        logic [MAGIC_W-1:0] pick;
        pick = $urandom;
        settle();
        write_magic('0);
        build_image('0, '{0, 0, 0, 0}, 4'b0000, 0, 25);
        stream_image();
        build_image(MAGIC_RESET, '{0, 0, 0, 0}, 4'b0000, 0, 25);
        stream_image();
        settle();
        write_magic(pick);
    endtask

    // Mostly well-formed images with random content and faults, the rest noise
    task automatic test_random_images();
        int       start;
        int       n;
        logic [MAGIC_W-1:0] magic;
        logic [SEG_COUNT-1:0] bad;
        start = beats_sent;
        while (beats_sent - start < 100) begin
            if ($urandom_range(9) < 7) begin
                magic = ($urandom_range(9) == 0) ? MAGIC_W'($urandom) : magic_reg;
                bad   = ($urandom_range(3) == 0) ? SEG_COUNT'($urandom) : '0;
                build_image(magic, pick_lengths(), bad,
                            ($urandom_range(2) == 0) ? $urandom_range(1, 6) : 0,
                            $urandom_range(5, 40));
                if ($urandom_range(7) == 0) begin
                    cut_image($urandom_range(1, image_bytes.size() - 1));
                end
            end else begin
                // Noise: random bytes, sometimes led by the right magic
                n = $urandom_range(1, 90);
                image_bytes.delete();
                repeat (n) image_bytes.push_back(8'($urandom_range(255)));
                if (n >= 4 && $urandom_range(1) == 0) begin
                    for (int i = 0; i < 4; i++) begin
                        image_bytes[i] = magic_reg[8*i +: 8];
                    end
                end
            end
            stream_image();
            // Now and then let everything drain before carrying on
            if ($urandom_range(7) == 0) begin
                settle();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        int sum_fails;
        magic_reg = MAGIC_RESET;
        clear_image_state();
        foreach (verdict_tally[i]) begin
            verdict_tally[i] = 0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_key_count_wrap();
        test_empty_segments();
        test_error_priority();
        test_truncation();
        test_magic_register();
        test_random_images();
        settle();

        if (beats_due.size() != 0) begin
            $error("%0d expected result beats never arrived", beats_due.size());
            fail_count++;
        end
        sum_fails = 0;
        for (int k = 0; k < SEG_COUNT; k++) begin
            sum_fails += verdict_tally[VERD_SEG_BASE + 3'(k)];
        end
        $display("Streamed %0d beats in %0d images; magic register written %0d times.",
                 beats_sent, images_sent, magic_writes);
        $display("Verdicts: %0d ok, %0d bad magic, %0d segment sum, %0d truncated.",
                 verdict_tally[VERD_OK], verdict_tally[VERD_MAGIC],
                 sum_fails, verdict_tally[VERD_TRUNC]);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
